// File: src/mbrm_pkg.sv
package mbrm_pkg;

  localparam int MAX_REGS_DEF = 30;

  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [7:0]  FUNC_READ = 8'h03;
  localparam logic [7:0]  SLAVE_ADDR_RST = 8'h01;

  // Input item codes.
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_BADCNT  = 2'd1;
  localparam logic [1:0] STAT_TIMEOUT = 2'd2;
  localparam logic [1:0] STAT_CRCERR  = 2'd3;

  typedef enum logic [2:0] {
    ST_READY,
    ST_TX,
    ST_STATUS,
    ST_WRD_RD,
    ST_WRD_OUT
  } state_t;

  // CRC-16/MODBUS update over one byte, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/mbrm_ram.sv
module mbrm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 30,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/modbus_rtu_read_master.sv
// Channel  Direction  Handshake                Payload
// in_      slave      in_tvalid / in_tready    tuser op, tdata start/count/rx byte
// out_     master     out_tvalid / out_tready  tuser kind, tdata, tlast last
// cfg_     slave      cfg_valid / cfg_ready    cfg_data slave address
//
// Received bytes are taken in the ready state. A start is accepted, then its eight
// request bytes go out, one per cycle while the output drains; a status goes out from
// its own state. After a good CRC the final reply byte starts readback of the stored
// words from the word RAM, a read and an output state per word (its read is registered).
// Reset is synchronous; no clearing pass is needed. A stalled output holds the emitting
// sequence in place; received bytes are still taken whenever no result run is emitted.
module modbus_rtu_read_master #(
  parameter int MAX_REGS = mbrm_pkg::MAX_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // op
  input  logic [31:0] in_tdata,   // start_register[15:0], register_count[23:16], rx_byte[31:24]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // kind
  output logic [31:0] out_tdata,  // tx_byte[7:0], reg_value[23:8], reg_index[28:24], status[30:29]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int AW     = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int WCNT_W = $clog2(MAX_REGS + 1);
  localparam int BCNT_W = $clog2(2 * MAX_REGS + 6);

  mbrm_pkg::state_t state_r, state_nxt;

  logic              rx_active_r, rx_active_nxt;
  logic [WCNT_W-1:0] words_r, words_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic [7:0]        hold_r, hold_nxt;
  logic [7:0]        slave_addr_r;
  logic [2:0]        tx_idx_r, tx_idx_nxt;
  logic [15:0]       start_r, start_nxt;
  logic [7:0]        count_r, count_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [WCNT_W-1:0] rd_idx_r, rd_idx_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_txb_r, out_txb_nxt;
  logic [15:0] out_val_r, out_val_nxt;
  logic [4:0]  out_idx_r, out_idx_nxt;
  logic [1:0]  out_st_r, out_st_nxt;
  logic        out_last_r, out_last_nxt;
  logic        out_load;
  logic        out_free;

  logic              in_fire;
  logic [1:0]        op;
  logic [15:0]       in_start;
  logic [7:0]        in_count;
  logic [7:0]        in_rxb;

  logic [BCNT_W-1:0] exp_m1, exp_m2, off, off_half;
  logic [WCNT_W-1:0] rd_next;
  logic [7:0]        tx_byte;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [15:0]       ram_wdata, ram_rdata;

  assign op       = in_tuser;
  assign in_start = in_tdata[15:0];
  assign in_count = in_tdata[23:16];
  assign in_rxb   = in_tdata[31:24];

  assign in_tready = (state_r == mbrm_pkg::ST_READY);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;

  // Reply frame is 5 + 2n bytes; the CRC covers all but the last two.
  assign exp_m1   = BCNT_W'({words_r, 1'b0}) + BCNT_W'(4);
  assign exp_m2   = BCNT_W'({words_r, 1'b0}) + BCNT_W'(3);
  assign off      = bcnt_r - BCNT_W'(3);
  assign off_half = off >> 1;
  assign rd_next  = rd_idx_r + 1'b1;

  always_comb begin
    unique case (tx_idx_r)
      3'd0: tx_byte = slave_addr_r;
      3'd1: tx_byte = mbrm_pkg::FUNC_READ;
      3'd2: tx_byte = start_r[15:8];
      3'd3: tx_byte = start_r[7:0];
      3'd4: tx_byte = 8'h00;
      3'd5: tx_byte = count_r;
      3'd6: tx_byte = crc_r[7:0];
      3'd7: tx_byte = crc_r[15:8];
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    rx_active_nxt = rx_active_r;
    words_nxt     = words_r;
    bcnt_nxt      = bcnt_r;
    crc_nxt       = crc_r;
    hold_nxt      = hold_r;
    tx_idx_nxt    = tx_idx_r;
    start_nxt     = start_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    rd_idx_nxt    = rd_idx_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = off_half[AW-1:0];
    ram_wdata     = {hold_r, in_rxb};
    out_load      = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_txb_nxt   = out_txb_r;
    out_val_nxt   = out_val_r;
    out_idx_nxt   = out_idx_r;
    out_st_nxt    = out_st_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      mbrm_pkg::ST_READY: begin
        if (in_fire) begin
          unique case (op)
            mbrm_pkg::OP_START: begin
              if (in_count == 8'd0 || int'(in_count) > MAX_REGS) begin
                rx_active_nxt = 1'b0;
                status_nxt    = mbrm_pkg::STAT_BADCNT;
                state_nxt     = mbrm_pkg::ST_STATUS;
              end else begin
                rx_active_nxt = 1'b1;
                words_nxt     = WCNT_W'(in_count);
                bcnt_nxt      = '0;
                crc_nxt       = mbrm_pkg::CRC_INIT;
                hold_nxt      = 8'h00;
                start_nxt     = in_start;
                count_nxt     = in_count;
                tx_idx_nxt    = 3'd0;
                state_nxt     = mbrm_pkg::ST_TX;
              end
            end
            mbrm_pkg::OP_BYTE: begin
              if (rx_active_r) begin
                bcnt_nxt = bcnt_r + 1'b1;
                if (bcnt_r < exp_m2) begin
                  crc_nxt = mbrm_pkg::crc16_byte(crc_r, in_rxb);
                end
                if (bcnt_r < exp_m1) begin
                  // Data bytes pair up big-endian; the low CRC byte lands in the latch.
                  if (bcnt_r >= BCNT_W'(3)) begin
                    if (!off[0]) begin
                      hold_nxt = in_rxb;
                    end else begin
                      ram_we = 1'b1;
                    end
                  end
                end else begin
                  rx_active_nxt = 1'b0;
                  rd_idx_nxt    = '0;
                  if ({in_rxb, hold_r} != crc_r) begin
                    status_nxt = mbrm_pkg::STAT_CRCERR;
                    state_nxt  = mbrm_pkg::ST_STATUS;
                  end else begin
                    state_nxt = mbrm_pkg::ST_WRD_RD;
                  end
                end
              end
            end
            mbrm_pkg::OP_TIMEOUT: begin
              if (rx_active_r) begin
                rx_active_nxt = 1'b0;
                status_nxt    = mbrm_pkg::STAT_TIMEOUT;
                state_nxt     = mbrm_pkg::ST_STATUS;
              end
            end
            default: begin
            end
          endcase
        end
      end
      mbrm_pkg::ST_TX: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = mbrm_pkg::KIND_TX;
          out_txb_nxt  = tx_byte;
          out_val_nxt  = 16'h0000;
          out_idx_nxt  = 5'd0;
          out_st_nxt   = mbrm_pkg::STAT_OK;
          out_last_nxt = (tx_idx_r == 3'd7);
          tx_idx_nxt   = tx_idx_r + 1'b1;
          if (tx_idx_r < 3'd6) begin
            crc_nxt = mbrm_pkg::crc16_byte(crc_r, tx_byte);
          end
          if (tx_idx_r == 3'd7) begin
            // The same register then runs the reply CRC.
            crc_nxt   = mbrm_pkg::CRC_INIT;
            state_nxt = mbrm_pkg::ST_READY;
          end
        end
      end
      mbrm_pkg::ST_STATUS: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = mbrm_pkg::KIND_STATUS;
          out_txb_nxt  = 8'h00;
          out_val_nxt  = 16'h0000;
          out_idx_nxt  = 5'd0;
          out_st_nxt   = status_r;
          out_last_nxt = 1'b1;
          state_nxt    = mbrm_pkg::ST_READY;
        end
      end
      mbrm_pkg::ST_WRD_RD: begin
        ram_re    = 1'b1;
        state_nxt = mbrm_pkg::ST_WRD_OUT;
      end
      mbrm_pkg::ST_WRD_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = mbrm_pkg::KIND_WORD;
          out_txb_nxt  = 8'h00;
          out_val_nxt  = ram_rdata;
          out_idx_nxt  = 5'(rd_idx_r);
          out_st_nxt   = mbrm_pkg::STAT_OK;
          out_last_nxt = (rd_next == words_r);
          rd_idx_nxt   = rd_next;
          state_nxt    = (rd_next == words_r) ? mbrm_pkg::ST_READY : mbrm_pkg::ST_WRD_RD;
        end
      end
      default: begin
        state_nxt = mbrm_pkg::ST_READY;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mbrm_pkg::ST_READY;
      rx_active_r  <= 1'b0;
      words_r      <= '0;
      bcnt_r       <= '0;
      crc_r        <= mbrm_pkg::CRC_INIT;
      hold_r       <= 8'h00;
      slave_addr_r <= mbrm_pkg::SLAVE_ADDR_RST;
      tx_idx_r     <= 3'd0;
      rd_idx_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rx_active_r <= rx_active_nxt;
      words_r     <= words_nxt;
      bcnt_r      <= bcnt_nxt;
      crc_r       <= crc_nxt;
      hold_r      <= hold_nxt;
      tx_idx_r    <= tx_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        slave_addr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r    <= start_nxt;
    count_r    <= count_nxt;
    status_r   <= status_nxt;
    out_kind_r <= out_kind_nxt;
    out_txb_r  <= out_txb_nxt;
    out_val_r  <= out_val_nxt;
    out_idx_r  <= out_idx_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  mbrm_ram #(
    .WIDTH(16),
    .DEPTH(MAX_REGS)
  ) u_words (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(rd_idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {1'b0, out_st_r, out_idx_r, out_val_r, out_txb_r};
  assign out_tlast  = out_last_r;

  // The word RAM is never written while its contents are being read back.
  a_no_write_on_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mbrm_pkg::ST_WRD_RD || state_r == mbrm_pkg::ST_WRD_OUT) |-> !ram_we)
    else $error("word RAM written during readout");

  // Readout never runs past the number of words requested.
  a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mbrm_pkg::ST_WRD_OUT) |-> (rd_idx_r < words_r))
    else $error("word readout index out of range");

  // While receiving, the byte counter stays inside the reply frame.
  a_bcnt_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    rx_active_r |-> (bcnt_r <= exp_m1))
    else $error("reply byte counter overran the frame");

  // A word result comes from a RAM read, possibly held over a stalled output.
  a_word_from_readout: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_kind_nxt == mbrm_pkg::KIND_WORD) |->
      ($past(ram_re) || $past(state_r == mbrm_pkg::ST_WRD_OUT)))
    else $error("word emitted without a RAM read");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_REGS = mbrm_pkg::MAX_REGS_DEF;
  localparam int RUN_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum int {REPLY_GOOD, REPLY_BAD_CRC, REPLY_CUT} reply_mode_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tx;
    logic [15:0] value;
    logic [4:0]  index;
    logic [1:0]  status;
    logic        last;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = OP_UNUSED;  // op
  logic [31:0] in_tdata = '0;         // start_register, register_count, rx_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;             // kind
  logic [31:0] out_tdata;             // tx_byte, reg_value, reg_index, status
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  modbus_rtu_read_master u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Mirror of the master's state.
  logic [7:0]  mb_slave_addr = 8'd1;
  logic        mb_receiving = 1'b0;
  int          mb_words_req = 0;
  int          mb_rx_pos = 0;
  logic [15:0] mb_reply_crc = 16'hFFFF;
  logic [7:0]  mb_held_byte = 8'h00;
  logic [15:0] mb_word_store [MAX_REGS];

  result_t pending_results[$];

  bit no_idle = 1'b0;
  int errors = 0;
  int cycles = 0;
  int live_items = 0;
  int n_frames = 0;
  int n_words = 0;
  int n_crc_errors = 0;
  int n_timeouts = 0;
  int n_bad_counts = 0;
  int n_cfg_writes = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding",
             cycles, pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int k;
    c = crc ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ 16'hA001;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic void expect_result(input logic [1:0] kind, input logic [7:0] tx,
      input logic [15:0] value, input logic [4:0] index, input logic [1:0] status,
      input logic last);
    result_t r;
    r.kind = kind;
    r.tx = tx;
    r.value = value;
    r.index = index;
    r.status = status;
    r.last = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_master_results(input logic [1:0] op,
      input logic [15:0] start, input logic [7:0] count, input logic [7:0] rx);
    logic [7:0]  frame [8];
    logic [15:0] crc;
    int pos;
    int total;
    int i;
    case (op)
      mbrm_pkg::OP_START: begin
        live_items++;
        if (count == 0 || count > MAX_REGS) begin
          mb_receiving = 1'b0;
          n_bad_counts++;
          expect_result(mbrm_pkg::KIND_STATUS, 8'h00, 16'h0000, 5'd0,
                        mbrm_pkg::STAT_BADCNT, 1'b1);
        end else begin
          frame[0] = mb_slave_addr;
          frame[1] = mbrm_pkg::FUNC_READ;
          frame[2] = start[15:8];
          frame[3] = start[7:0];
          frame[4] = 8'h00;
          frame[5] = count;
          crc = 16'hFFFF;
          for (i = 0; i < 6; i++) crc = crc_step(crc, frame[i]);
          frame[6] = crc[7:0];
          frame[7] = crc[15:8];
          for (i = 0; i < 8; i++) begin
            expect_result(mbrm_pkg::KIND_TX, frame[i], 16'h0000, 5'd0, mbrm_pkg::STAT_OK,
                          i == 7);
          end
          // A start always opens a fresh exchange, even over one in progress.
          mb_receiving = 1'b1;
          mb_words_req = int'(count);
          mb_rx_pos = 0;
          mb_reply_crc = 16'hFFFF;
          mb_held_byte = 8'h00;
          n_frames++;
        end
      end
      mbrm_pkg::OP_TIMEOUT: begin
        if (mb_receiving) begin
          live_items++;
          mb_receiving = 1'b0;
          n_timeouts++;
          expect_result(mbrm_pkg::KIND_STATUS, 8'h00, 16'h0000, 5'd0,
                        mbrm_pkg::STAT_TIMEOUT, 1'b1);
        end
      end
      mbrm_pkg::OP_BYTE: begin
        if (mb_receiving) begin
          live_items++;
          total = 5 + 2 * mb_words_req;
          pos = mb_rx_pos;
          mb_rx_pos++;
          if (pos + 2 < total) mb_reply_crc = crc_step(mb_reply_crc, rx);
          if (pos + 1 < total) begin
            // Even offsets from byte 3 on are word high bytes; the CRC low byte
            // lands in the same holding register.
            if (pos >= 3) begin
              if (((pos - 3) % 2) == 0) mb_held_byte = rx;
              else mb_word_store[(pos - 3) / 2] = {mb_held_byte, rx};
            end
          end else begin
            mb_receiving = 1'b0;
            if ({rx, mb_held_byte} != mb_reply_crc) begin
              n_crc_errors++;
              expect_result(mbrm_pkg::KIND_STATUS, 8'h00, 16'h0000, 5'd0,
                            mbrm_pkg::STAT_CRCERR, 1'b1);
            end else begin
              for (i = 0; i < mb_words_req; i++) begin
                expect_result(mbrm_pkg::KIND_WORD, 8'h00, mb_word_store[i], i[4:0],
                              mbrm_pkg::STAT_OK, i + 1 == mb_words_req);
                n_words++;
              end
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic string fmt_result(input result_t r);
    return $sformatf("kind=%0d tx=%02h value=%04h index=%0d status=%0d last=%0b",
                     r.kind, r.tx, r.value, r.index, r.status, r.last);
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] %s", $realtime, msg);
  endfunction

  // Result checker.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.tx = out_tdata[7:0];
      got.value = out_tdata[23:8];
      got.index = out_tdata[28:24];
      got.status = out_tdata[30:29];
      got.last = out_tlast;
      if (pending_results.size() == 0) begin
        note_error({"unexpected result: ", fmt_result(got)});
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          note_error({"mismatch: expected ", fmt_result(want), " got ", fmt_result(got)});
        end
      end
    end
  end

  // Result sink: random stalls drawn each cycle plus an occasional longer one, none while no_idle is set.
  always @(posedge clk) begin
    int hold;
    if (hold > 0) begin
      hold--;
      out_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 1) begin
      hold = $urandom_range(3, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= 18);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [15:0] start,
      input logic [7:0] count, input logic [7:0] rx);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {rx, count, start};
    do @(posedge clk); while (!in_tready);
    predict_master_results(op, start, count, rx);
    if (!no_idle && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 40);
    end
  endtask

  // Plays the slave's reply to a read of n_words registers, good, with a bad CRC or cut short as mode asks.
  task automatic send_reply(input int n_words, input reply_mode_t mode);
    logic [7:0]  reply [5 + 2 * MAX_REGS];
    logic [15:0] crc;
    int total;
    int stop;
    int i;
    total = 5 + 2 * n_words;
    reply[0] = ($urandom_range(0, 99) < 80) ? mb_slave_addr : 8'($urandom);
    reply[1] = ($urandom_range(0, 99) < 80) ? mbrm_pkg::FUNC_READ : 8'($urandom);
    reply[2] = ($urandom_range(0, 99) < 80) ? 8'(2 * n_words) : 8'($urandom);
    for (i = 3; i < total - 2; i++) reply[i] = 8'($urandom);
    crc = 16'hFFFF;
    for (i = 0; i < total - 2; i++) crc = crc_step(crc, reply[i]);
    if (mode == REPLY_BAD_CRC) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    reply[total - 2] = crc[7:0];
    reply[total - 1] = crc[15:8];
    stop = (mode == REPLY_CUT) ? $urandom_range(0, total - 1) : total;
    for (i = 0; i < stop; i++) begin
      send_item(mbrm_pkg::OP_BYTE, 16'($urandom), 8'($urandom), reply[i]);
    end
  endtask

  task automatic start_read(input logic [15:0] start, input int n_words);
    send_item(mbrm_pkg::OP_START, start, 8'(n_words), 8'($urandom));
  endtask

  // Waits until the master has drained everything and gone quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_slave_address(input logic [7:0] addr);
    cfg_valid <= 1'b1;
    cfg_data <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mb_slave_addr = addr;
    n_cfg_writes++;
  endtask

  task automatic test_bad_counts();
    send_item(mbrm_pkg::OP_START, 16'h1234, 8'd0, 8'($urandom));
    send_item(mbrm_pkg::OP_START, 16'h0001, 8'(MAX_REGS + 1), 8'($urandom));
    send_item(mbrm_pkg::OP_START, 16'hFFFF, 8'hFF, 8'($urandom));
  endtask

  task automatic test_ignored_when_idle();
    send_item(mbrm_pkg::OP_BYTE, 16'($urandom), 8'($urandom), 8'hFF);
    send_item(mbrm_pkg::OP_TIMEOUT, 16'($urandom), 8'($urandom), 8'($urandom));
    send_item(OP_UNUSED, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_single_word_read();
    start_read(16'hFFFF, 1);
    send_reply(1, REPLY_GOOD);
  endtask

  // A second start abandons the half-received reply; the new one fails its CRC.
  task automatic test_restart_and_crc_error();
    start_read(16'h0000, 2);
    send_item(mbrm_pkg::OP_BYTE, 16'($urandom), 8'($urandom), mb_slave_addr);
    send_item(mbrm_pkg::OP_BYTE, 16'($urandom), 8'($urandom), mbrm_pkg::FUNC_READ);
    start_read(16'($urandom), 1);
    send_reply(1, REPLY_BAD_CRC);
  endtask

  task automatic test_timeout_while_receiving();
    start_read(16'($urandom), MAX_REGS);
    send_item(mbrm_pkg::OP_BYTE, 16'($urandom), 8'($urandom), 8'h00);
    send_item(mbrm_pkg::OP_TIMEOUT, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic test_largest_read();
    start_read(16'($urandom), MAX_REGS);
    send_reply(MAX_REGS, REPLY_GOOD);
  endtask

  // Mostly complete exchanges with random content, the rest broken or noise.
  task automatic test_random_traffic(input int item_goal);
    int goal_at;
    int n;
    int roll;
    goal_at = live_items + item_goal;
    while (live_items < goal_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        n = ($urandom_range(0, 99) < 4) ? MAX_REGS : $urandom_range(1, 6);
        start_read(16'($urandom), n);
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          send_reply(n, REPLY_GOOD);
        end else if (roll < 87) begin
          send_reply(n, REPLY_BAD_CRC);
        end else begin
          send_reply(n, REPLY_CUT);
          if ($urandom_range(0, 1)) begin
            send_item(mbrm_pkg::OP_TIMEOUT, 16'($urandom), 8'($urandom), 8'($urandom));
          end
        end
      end else if (roll < 78) begin
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_REGS + 1, 255);
        send_item(mbrm_pkg::OP_START, 16'($urandom), 8'(n), 8'($urandom));
      end else begin
        send_item(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_bad_counts();
    test_ignored_when_idle();
    settle();
    write_slave_address(8'h00);
    test_single_word_read();
    settle();
    write_slave_address(8'hFF);
    test_restart_and_crc_error();
    test_timeout_while_receiving();
    settle();
    write_slave_address(8'($urandom));

    no_idle = 1'b1;
    test_largest_read();
    test_random_traffic(6);
    settle();
    no_idle = 1'b0;
    write_slave_address(8'($urandom));
    test_random_traffic(6);
    settle();
    write_slave_address(8'($urandom));
    test_random_traffic(6);
    settle();

    $display("Covered %0d request frames, %0d register words, %0d CRC errors, %0d timeouts",
             n_frames, n_words, n_crc_errors, n_timeouts);
    $display("and %0d bad counts over %0d live requests, %0d address writes, %0d mismatches.",
             n_bad_counts, live_items, n_cfg_writes, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
